// ===== rtl/core/mic_pkg.sv =====
package mic_pkg;

    localparam int MAX_SIZE_DEF  = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 64;
    localparam int IDX_W         = 2;
    localparam int SIZE_W        = 3;
    localparam int ENTRY_W       = 8;
    // Products of up to four 8-bit entries plus sums fit in 40 bits.
    localparam int ACC_W         = 40;

    localparam logic KIND_DET = 1'b0;
    localparam logic KIND_INV = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DET_START,
        ST_DET_WAIT,
        ST_DET_OUT,
        ST_COF_START,
        ST_COF_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_INV_OUT
    } state_t;

    // permutation-sum sequencer phases
    typedef enum logic [1:0] { PH_CHECK, PH_MUL, PH_ADV } phase_t;

    typedef struct packed {
        logic det_start;  // compute determinant of full matrix
        logic cof_start;  // compute cofactor for (row, col) of inverse
        logic div_start;  // divide latched cofactor by determinant
        logic emit_det;   // load output register with determinant
        logic emit_inv;   // load output register with quotient
    } cmd_t;

    typedef struct packed {
        logic calc_done;
        logic div_done;
        logic det_zero;
    } status_t;

endpackage

// ===== rtl/core/mic_ram.sv =====
module mic_ram
    import mic_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mic_ctrl.sv =====
module mic_ctrl
    import mic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] size_eff,
    input  logic              in_fire,
    input  logic              out_busy,
    input  status_t           status,
    output cmd_t              cmd,
    output logic              in_stall,
    output logic [2:0]        row,
    output logic [2:0]        col,
    output logic              last
);

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] row_reg, row_next, col_reg, col_next;
    logic [5:0] total;

    assign total = 6'(size_eff) * 6'(size_eff);
    assign last  = (row_reg == 3'(size_eff - 1'b1)) && (col_reg == 3'(size_eff - 1'b1));
    assign row   = row_reg;
    assign col   = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (cfg_we)
                begin
                    cnt_next = '0;
                end
                else if (in_fire)
                begin
                    if (cnt_reg + 6'd1 >= total)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DET_START;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            ST_DET_START:
            begin
                cmd.det_start = 1'b1;
                state_next    = ST_DET_WAIT;
            end
            ST_DET_WAIT:
            begin
                if (status.calc_done)
                begin
                    state_next = ST_DET_OUT;
                end
            end
            ST_DET_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.emit_det = 1'b1;
                    row_next     = '0;
                    col_next     = '0;
                    state_next   = status.det_zero ? ST_LOAD : ST_COF_START;
                end
            end
            ST_COF_START:
            begin
                cmd.cof_start = 1'b1;
                state_next    = ST_COF_WAIT;
            end
            ST_COF_WAIT:
            begin
                if (status.calc_done)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_INV_OUT;
                end
            end
            ST_INV_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.emit_inv = 1'b1;
                    if (last)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_COF_START;
                        if (col_reg == 3'(size_eff - 1'b1))
                        begin
                            col_next = '0;
                            row_next = row_reg + 3'd1;
                        end
                        else
                        begin
                            col_next = col_reg + 3'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/core/mic_dp.sv =====
module mic_dp
    import mic_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SIZE_W-1:0]  size_eff,
    input  logic               in_fire,
    input  logic [ENTRY_W-1:0] entry_value,
    input  logic               cfg_we,
    input  cmd_t               cmd,
    input  logic [2:0]         row,
    input  logic [2:0]         col,
    input  logic               last,
    input  logic               out_stall,
    output status_t            status,
    output logic               out_busy,
    output logic               valid,
    output logic               result_kind,
    output logic [VAL_W-1:0]   result_value,
    output logic [IDX_W-1:0]   row_index,
    output logic [IDX_W-1:0]   col_index,
    output logic               singular,
    output logic               last_result
);

    localparam int MAX_SIZE = MAX_SIZE_DEF;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    // ---------------- entry store ----------------
    logic [AW-1:0] waddr_reg, raddr;
    logic [ENTRY_W-1:0] rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waddr_reg <= '0;
        end
        else if (cfg_we)
        begin
            waddr_reg <= '0;
        end
        else if (in_fire)
        begin
            if (32'(waddr_reg) + 1 >= 32'(size_eff) * 32'(size_eff))
            begin
                waddr_reg <= '0;
            end
            else
            begin
                waddr_reg <= waddr_reg + 1'b1;
            end
        end
    end

    mic_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (waddr_reg),
        .wdata (entry_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ---------------- determinant by permutation sum ----------------
    // Leibniz sum over all permutations of the kept rows/columns: each product
    // term multiplies up to m entries, read one at a time from the store.
    // Permutations come from a digit counter with duplicate digits skipped
    // (base m over m positions).
    logic             calc_busy_reg;
    logic [2:0]       m_reg;        // order of the matrix being evaluated
    logic [2:0]       skip_r_reg, skip_c_reg;
    logic             skip_en_reg;
    logic [2:0]       perm_reg [MAX_SIZE];  // column choice per position
    logic [2:0]       pos_reg;              // position being multiplied
    logic             rd_pend_reg;
    logic signed [ACC_W-1:0] term_reg, acc_reg;
    logic             sign_reg;
    logic             cof_neg_reg;
    logic signed [ACC_W-1:0] det_reg, cof_reg;
    logic             is_det_reg;
    logic             done_reg;

    logic [2:0] phys_r, phys_c;
    logic       perm_ok;
    logic       inv_par;

    // map logical row/col of minor to physical index
    always_comb
    begin
        phys_r = pos_reg;
        phys_c = perm_reg[pos_reg[PW-1:0]];
        if (skip_en_reg && phys_r >= skip_r_reg) phys_r = phys_r + 3'd1;
        if (skip_en_reg && phys_c >= skip_c_reg) phys_c = phys_c + 3'd1;
        raddr = AW'(32'(phys_r) * 32'(size_eff) + 32'(phys_c));
    end

    // validity and parity of current digit tuple
    always_comb
    begin
        perm_ok = 1'b1;
        inv_par = 1'b0;
        for (int a = 0; a < MAX_SIZE; a++)
        begin
            for (int b = 0; b < MAX_SIZE; b++)
            begin
                if (a < b && b < int'(m_reg))
                begin
                    if (perm_reg[a] == perm_reg[b]) perm_ok = 1'b0;
                    if (perm_reg[a] > perm_reg[b]) inv_par = ~inv_par;
                end
            end
        end
    end

    phase_t phase_reg;
    logic   last_tuple;

    always_comb
    begin
        last_tuple = 1'b1;
        for (int a = 0; a < MAX_SIZE; a++)
        begin
            if (a < int'(m_reg) && perm_reg[a] != 3'(m_reg - 3'd1)) last_tuple = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_busy_reg <= 1'b0;
            done_reg      <= 1'b0;
            phase_reg     <= PH_CHECK;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.det_start || cmd.cof_start)
            begin
                calc_busy_reg <= 1'b1;
                is_det_reg    <= cmd.det_start;
                m_reg         <= cmd.det_start ? size_eff : 3'(size_eff - 1'b1);
                skip_en_reg   <= cmd.cof_start;
                // inverse (r,c) uses cofactor of (c,r)
                skip_r_reg    <= col;
                skip_c_reg    <= row;
                cof_neg_reg   <= row[0] ^ col[0];
                for (int a = 0; a < MAX_SIZE; a++) perm_reg[a] <= '0;
                acc_reg       <= '0;
                phase_reg     <= PH_CHECK;
                rd_pend_reg   <= 1'b0;
            end
            else if (calc_busy_reg)
            begin
                case (phase_reg)
                    PH_CHECK:
                    begin
                        if (m_reg == 3'd0)
                        begin
                            acc_reg       <= ACC_W'(1);
                            phase_reg     <= PH_ADV;
                        end
                        else if (perm_ok)
                        begin
                            sign_reg    <= inv_par;
                            term_reg    <= ACC_W'(1);
                            pos_reg     <= '0;
                            rd_pend_reg <= 1'b0;
                            phase_reg   <= PH_MUL;
                        end
                        else
                        begin
                            phase_reg <= PH_ADV;
                        end
                    end
                    PH_MUL:
                    begin
                        // address presented this cycle, data next cycle
                        if (!rd_pend_reg)
                        begin
                            rd_pend_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_pend_reg <= 1'b0;
                            term_reg <= ACC_W'(term_reg * $signed(rdata));
                            if (pos_reg == 3'(m_reg - 3'd1))
                            begin
                                phase_reg <= PH_ADV;
                                acc_reg   <= sign_reg
                                    ? acc_reg - ACC_W'(term_reg * $signed(rdata))
                                    : acc_reg + ACC_W'(term_reg * $signed(rdata));
                            end
                            else
                            begin
                                pos_reg <= pos_reg + 3'd1;
                            end
                        end
                    end
                    PH_ADV:
                    begin
                        if (m_reg == 3'd0 || last_tuple)
                        begin
                            calc_busy_reg <= 1'b0;
                            done_reg      <= 1'b1;
                            if (is_det_reg)
                            begin
                                det_reg <= acc_reg;
                            end
                            else
                            begin
                                cof_reg <= cof_neg_reg ? -acc_reg : acc_reg;
                            end
                        end
                        else
                        begin
                            // increment base-m digit counter, last digit fastest
                            for (int a = MAX_SIZE - 1; a >= 0; a--)
                            begin
                                if (a < int'(m_reg))
                                begin
                                    automatic logic carry_in = 1'b1;
                                    for (int b = a + 1; b < MAX_SIZE; b++)
                                    begin
                                        if (b < int'(m_reg) && perm_reg[b] != 3'(m_reg - 3'd1))
                                            carry_in = 1'b0;
                                    end
                                    if (carry_in)
                                    begin
                                        perm_reg[a] <= (perm_reg[a] == 3'(m_reg - 3'd1))
                                            ? 3'd0 : perm_reg[a] + 3'd1;
                                    end
                                end
                            end
                            phase_reg <= PH_CHECK;
                        end
                    end
                    default:
                    begin
                        phase_reg <= PH_CHECK;
                    end
                endcase
            end
        end
    end

    // ---------------- fixed-point restoring divider ----------------
    // Divides |cof| * 2^FRAC_BITS by |det|, one quotient bit per cycle.
    localparam int NUM_W = ACC_W + FRAC_BITS;
    localparam int QCNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] dnum_reg, quo_reg;
    logic [ACC_W:0]   rem_reg;
    logic [ACC_W-1:0] dden_reg;
    logic [QCNT_W-1:0] dcnt_reg;
    logic             dbusy_reg, ddone_reg, dneg_reg;
    logic [ACC_W:0]   rem_sh;

    assign rem_sh = {rem_reg[ACC_W-1:0], dnum_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= '0;
                rem_reg   <= '0;
                quo_reg   <= '0;
                dneg_reg  <= cof_reg[ACC_W-1] ^ det_reg[ACC_W-1];
                dnum_reg  <= {(cof_reg[ACC_W-1] ? -cof_reg : cof_reg),
                              {FRAC_BITS{1'b0}}};
                dden_reg  <= det_reg[ACC_W-1] ? -det_reg : det_reg;
            end
            else if (dbusy_reg)
            begin
                dnum_reg <= dnum_reg << 1;
                if (rem_sh >= {1'b0, dden_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, dden_reg};
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
                if (dcnt_reg == QCNT_W'(NUM_W - 1))
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
                else
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
            end
        end
    end

    // quotient magnitude fits well under 63 bits, so no saturation occurs
    logic [VAL_W-1:0] quo_ext;
    assign quo_ext = VAL_W'(quo_reg);

    assign status.calc_done = done_reg;
    assign status.div_done  = ddone_reg;
    assign status.det_zero  = (det_reg == '0);

    // ---------------- output register ----------------
    logic             valid_reg;
    logic             kind_reg, sing_reg, lastr_reg;
    logic [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0] ri_reg, ci_reg;

    assign out_busy = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit_det || cmd.emit_inv)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_det)
        begin
            kind_reg  <= KIND_DET;
            val_reg   <= VAL_W'(det_reg);
            ri_reg    <= '0;
            ci_reg    <= '0;
            sing_reg  <= (det_reg == '0);
            lastr_reg <= (det_reg == '0);
        end
        else if (cmd.emit_inv)
        begin
            kind_reg  <= KIND_INV;
            val_reg   <= dneg_reg ? -quo_ext : quo_ext;
            ri_reg    <= row[IDX_W-1:0];
            ci_reg    <= col[IDX_W-1:0];
            sing_reg  <= 1'b0;
            lastr_reg <= last;
        end
    end

    assign valid        = valid_reg;
    assign result_kind  = kind_reg;
    assign result_value = val_reg;
    assign row_index    = ri_reg;
    assign col_index    = ci_reg;
    assign singular     = sing_reg;
    assign last_result  = lastr_reg;

endmodule

// ===== rtl/core/matrix_inverse_by_cofactors_top.sv =====
// Matrix inverse by cofactors. Entries of an n-by-n matrix of signed 8-bit
// integers stream in row-major order, one item per cycle while loading.
// n comes from cfg_data (0 acts as 1, above MAX_SIZE acts as MAX_SIZE);
// writing it restarts the load. After the last entry the block emits the
// exact determinant (result_kind 0); if it is zero, singular and last_result
// are set and nothing follows. Otherwise n*n inverse entries follow in
// row-major order (result_kind 1), each the transposed cofactor over the
// determinant in signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero. Input is stalled from the last entry until the final result
// is loaded into the output register. Each determinant or cofactor runs a
// permutation-sum sequencer over all m^m digit tuples, checking every tuple
// and reading m entries for each of the m! true permutations, and each
// 40+FRAC_BITS-bit quotient comes from a one-bit-per-cycle divider.
module matrix_inverse_by_cofactors_top
    import mic_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SIZE_W-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [ENTRY_W-1:0] entry_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic [VAL_W-1:0]   result_value,
    output logic [IDX_W-1:0]   row_index,
    output logic [IDX_W-1:0]   col_index,
    output logic               singular,
    output logic               last_result
);

    logic [SIZE_W-1:0] size_reg, size_eff;
    logic              in_fire, out_busy, last;
    logic [2:0]        row, col;
    cmd_t              cmd;
    status_t           status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(4);
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_data;
        end
    end

    // clamp to 1..MAX_SIZE
    always_comb
    begin
        size_eff = size_reg;
        if (size_reg == '0) size_eff = SIZE_W'(1);
        if (32'(size_reg) > MAX_SIZE_DEF) size_eff = SIZE_W'(MAX_SIZE_DEF);
    end

    assign in_fire = in_valid && !in_stall;

    mic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .size_eff (size_eff),
        .in_fire  (in_fire),
        .out_busy (out_busy),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall),
        .row      (row),
        .col      (col),
        .last     (last)
    );

    mic_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .size_eff     (size_eff),
        .in_fire      (in_fire),
        .entry_value  (entry_value),
        .cfg_we       (cfg_we),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .last         (last),
        .out_stall    (out_stall),
        .status       (status),
        .out_busy     (out_busy),
        .valid        (out_valid),
        .result_kind  (result_kind),
        .result_value (result_value),
        .row_index    (row_index),
        .col_index    (col_index),
        .singular     (singular),
        .last_result  (last_result)
    );

endmodule

// ===== tb/sv/matrix_inverse_by_cofactors_top_tb.sv =====
`timescale 1ns / 100ps

module matrix_inverse_by_cofactors_top_tb;
    import mic_pkg::*;

    localparam int  N_MAX          = MAX_SIZE_DEF;
    localparam int  FRAC           = FRAC_BITS_DEF;
    localparam int  STALL_LIMIT    = 200000; // cycles with no handshake at all
    localparam int  SETTLE_CYCLES  = 60;     // quiet time before a size write
    localparam int  RANDOM_ENTRIES = 310;
    localparam int  PRESSURE_HOLD  = 400;

    typedef longint sq_mat_t [N_MAX][N_MAX];

    typedef struct {
        logic             kind;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             sing;
        logic             last;
    } inv_result_t;

    // DUT ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [SIZE_W-1:0]  cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ENTRY_W-1:0] entry_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               result_kind;
    logic [VAL_W-1:0]   result_value;
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic               singular;
    logic               last_result;

    // Scoreboard model state
    logic [ENTRY_W-1:0] shadow_store [N_MAX*N_MAX];
    int                 shadow_count = 0;
    logic [SIZE_W-1:0]  shadow_size = 3'd4;
    inv_result_t        pending_results [$];

    // Traffic shaping
    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    bit  pressure_req = 1'b0;
    int  error_count = 0;
    int  quiet_cycles = 0;

    matrix_inverse_by_cofactors_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .entry_value  (entry_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .result_value (result_value),
        .row_index    (row_index),
        .col_index    (col_index),
        .singular     (singular),
        .last_result  (last_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Arithmetic of the scoreboard model
    //------------------------------------------------------------------

    // size register as the block sees it: 0 acts as 1, above N_MAX clamps
    function automatic int order_of(input logic [SIZE_W-1:0] sz);
        if (sz == 0)
            return 1;
        if (sz > N_MAX)
            return N_MAX;
        return int'(sz);
    endfunction

    function automatic sq_mat_t strike(input sq_mat_t a, input int m,
                                       input int dr, input int dc);
        sq_mat_t sub;
        int      r;
        int      c;
        sub = '{default: 0};
        r = 0;
        for (int i = 0; i < m; i++)
        begin
            if (i == dr)
                continue;
            c = 0;
            for (int j = 0; j < m; j++)
            begin
                if (j == dc)
                    continue;
                sub[r][c] = a[i][j];
                c++;
            end
            r++;
        end
        return sub;
    endfunction

    // Laplace expansion on row 0; empty matrix counts as 1
    function automatic longint laplace_det(input sq_mat_t a, input int m);
        longint acc;
        longint sgn;
        if (m == 0)
            return 1;
        if (m == 1)
            return a[0][0];
        acc = 0;
        sgn = 1;
        for (int j = 0; j < m; j++)
        begin
            acc += sgn * a[0][j] * laplace_det(strike(a, m, 0, j), m - 1);
            sgn = -sgn;
        end
        return acc;
    endfunction

    // (num << FRAC) / den, toward zero, saturated to 64 bits signed
    function automatic logic [63:0] fixed_quotient(input longint num, input longint den);
        logic [63:0] n_mag;
        logic [63:0] d_mag;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] lim;
        bit          neg;
        bit          over;
        n_mag = (num < 0) ? 64'd0 - num : num;
        d_mag = (den < 0) ? 64'd0 - den : den;
        q = n_mag / d_mag;
        r = n_mag % d_mag;
        neg = (num < 0) != (den < 0);
        over = 1'b0;
        for (int k = 0; k < FRAC; k++)
        begin
            if (q[63])
                over = 1'b1;
            q = q << 1;
            r = r << 1;
            if (r >= d_mag)
            begin
                r = r - d_mag;
                q[0] = 1'b1;
            end
        end
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (over || q > lim)
            q = lim;
        return neg ? 64'd0 - q : q;
    endfunction

    // One accepted entry: store it, and on the last entry of the matrix
    // queue the determinant item and, unless singular, the n*n inverse items.
    function automatic void absorb_entry(input logic [ENTRY_W-1:0] v);
        int          n;
        sq_mat_t     a;
        longint      det;
        longint      cof;
        inv_result_t res;
        n = order_of(shadow_size);
        if (shadow_count >= n * n)
            shadow_count = 0;
        shadow_store[shadow_count] = v;
        shadow_count++;
        if (shadow_count < n * n)
            return;
        shadow_count = 0;
        a = '{default: 0};
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                a[i][j] = longint'($signed(shadow_store[i*n + j]));
        det = laplace_det(a, n);
        res.kind  = KIND_DET;
        res.value = det;
        res.row   = '0;
        res.col   = '0;
        res.sing  = (det == 0);
        res.last  = (det == 0);
        pending_results.push_back(res);
        if (det == 0)
            return;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
            begin
                // transposed cofactor: minor without row j, column i
                cof = laplace_det(strike(a, n, j, i), n - 1);
                if ((i + j) % 2 == 1)
                    cof = -cof;
                res.kind  = KIND_INV;
                res.value = fixed_quotient(cof, det);
                res.row   = i[IDX_W-1:0];
                res.col   = j[IDX_W-1:0];
                res.sing  = 1'b0;
                res.last  = (i == n - 1) && (j == n - 1);
                pending_results.push_back(res);
            end
    endfunction

    //------------------------------------------------------------------
    // Driving
    //------------------------------------------------------------------

    // Send one entry item; valid stays up after acceptance so back-to-back
    // items need no drop. Random idle cycles come first.
    task automatic send_entry(input logic [ENTRY_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        entry_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        absorb_entry(v);
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every queued item to drain, then give partial loads time to
    // settle before writing the size register.
    task automatic write_size(input logic [SIZE_W-1:0] sz);
        release_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_size  = sz;
        shadow_count = 0;
    endtask

    task automatic send_matrix(input int n, input bit narrow);
        for (int k = 0; k < n * n; k++)
        begin
            // narrow values make singular matrices common
            if (narrow)
                send_entry(ENTRY_W'($urandom_range(4) - 2));
            else
                send_entry(ENTRY_W'($urandom));
        end
    endtask

    //------------------------------------------------------------------
    // Receiving side: random stall plus long hold-off on request
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : sink_stall
        int hold_left;
        if (pressure_req)
        begin
            hold_left    = PRESSURE_HOLD;
            pressure_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Output monitor
    always @(posedge clk)
    begin : result_check
        inv_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected item, value", result_value, 0);
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", result_kind, want.kind);
                if (result_value !== want.value)
                    report_mismatch("result_value", result_value, want.value);
                if (row_index !== want.row)
                    report_mismatch("row_index", row_index, want.row);
                if (col_index !== want.col)
                    report_mismatch("col_index", col_index, want.col);
                if (singular !== want.sing)
                    report_mismatch("singular", singular, want.sing);
                if (last_result !== want.last)
                    report_mismatch("last_result", last_result, want.last);
            end
        end
    end

    // Watchdog: trips only when no handshake happens for a long time
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL matrix_inverse_by_cofactors_top");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Reset size of 4: extreme entries; the nonzero diagonal keeps it nonsingular
    task automatic test_default_size();
        logic [ENTRY_W-1:0] m4 [16] = '{8'h80, 8'h00, 8'h00, 8'h00,
                                        8'h00, 8'h7F, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h01, 8'h00,
                                        8'h05, 8'h00, 8'h00, 8'hFF};
        foreach (m4[k])
            send_entry(m4[k]);
    endtask

    // Size 0 acts as 1: inverse is 2^FRAC / a; zero entry is singular
    task automatic test_one_by_one();
        write_size(3'd0);
        send_entry(8'h7F);
        send_entry(8'h80);
        send_entry(8'h00);
    endtask

    task automatic test_singular_pair();
        write_size(3'd2);
        send_entry(8'd1);
        send_entry(8'd2);
        send_entry(8'd2);
        send_entry(8'd4);
    endtask

    // Partial load abandoned by a size write; load starts over
    task automatic test_restart_load();
        write_size(3'd3);
        send_entry(8'd9);
        send_entry(8'hF7);
        write_size(3'd2);
        send_entry(8'd3);
        send_entry(8'd1);
        send_entry(8'd5);
        send_entry(8'd2);
    endtask

    // Output held off for a long stretch while entries keep coming
    task automatic test_backpressure();
        write_size(3'd2);
        pressure_req = 1'b1;
        for (int k = 0; k < 4; k++)
            send_matrix(2, 1'b0);
    endtask

    task automatic test_random_matrices();
        int sent;
        int pick;
        logic [SIZE_W-1:0] sz;
        sent = 0;
        while (sent < RANDOM_ENTRIES)
        begin
            // three traffic phases by progress
            case (sent * 3 / RANDOM_ENTRIES)
                0:       begin src_idle_pct = 34; sink_idle_pct = 69; end
                1:       begin src_idle_pct = 69; sink_idle_pct = 34; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            pick = $urandom_range(99);
            if (pick < 8)
                sz = 3'd1;
            else if (pick < 12)
                sz = 3'd0;
            else if (pick < 50)
                sz = 3'd2;
            else if (pick < 90)
                sz = 3'd3;
            else if (pick < 96)
                sz = 3'd4;
            else
                sz = 3'($urandom_range(7, 5));
            write_size(sz);
            for (int k = $urandom_range(4, 1); k > 0; k--)
            begin
                send_matrix(order_of(sz), $urandom_range(3) == 0);
                sent += order_of(sz) * order_of(sz);
                if (order_of(sz) == N_MAX)
                    break;
            end
            // occasional truncated load, dropped by the next size write
            if ($urandom_range(9) == 0)
                for (int k = $urandom_range(order_of(sz) * order_of(sz) - 1, 0); k > 0; k--)
                    send_entry(ENTRY_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle_pct  = 34;
        sink_idle_pct = 69;
        test_default_size();
        test_one_by_one();
        test_singular_pair();
        test_restart_load();
        test_backpressure();
        test_random_matrices();
        release_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("PASS matrix_inverse_by_cofactors_top");
        else
            $display("FAIL matrix_inverse_by_cofactors_top");
        $finish;
    end

endmodule
